/* hw/rtl/dvru_pkg.sv */
// Shared types, sizes and codes for the distance-vector route table.
`timescale 1ns / 1ps
package dvru_pkg;

    localparam int MAX_NODES = 32;
    localparam int NODE_BITS = $clog2(MAX_NODES);
    localparam int CNT_BITS  = NODE_BITS + 1;
    localparam int COST_BITS = 16;
    localparam int HOP_BITS  = 6;
    localparam int ADDR_BITS = 2 * NODE_BITS;
    localparam int CELLS     = MAX_NODES * MAX_NODES;

    localparam logic [HOP_BITS-1:0]  HOP_NONE = HOP_BITS'(MAX_NODES);
    localparam logic [COST_BITS-1:0] COST_MAX = {COST_BITS{1'b1}};

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_EXCH  = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD     = 2'd1;
    localparam logic [1:0] ST_NO_LINK = 2'd2;

    typedef struct packed {
        logic                 mark;
        logic [HOP_BITS-1:0]  hop;
        logic [COST_BITS-1:0] cost;
    } t_entry;

    localparam int ENTRY_BITS = $bits(t_entry);

    // Relaxation unit request and answer
    typedef struct packed {
        logic                 skip;
        logic [COST_BITS-1:0] to_send;
        logic [COST_BITS-1:0] via;
        logic [COST_BITS-1:0] old;
    } t_relax_req;

    typedef struct packed {
        logic                 take;
        logic [COST_BITS-1:0] sum;
    } t_relax_rsp;

endpackage

/* hw/rtl/dvru_ram.sv */
// Generic memory: one write port, two registered read ports.
`timescale 1ns / 1ps
module dvru_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 23
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr0,
    input  logic [ADDR_W-1:0] i_raddr1,
    output logic [DATA_W-1:0] o_rdata0,
    output logic [DATA_W-1:0] o_rdata1
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end

endmodule

/* hw/rtl/dvru_relax.sv */
// Saturating add and compare used once per table entry during an exchange.
`timescale 1ns / 1ps
module dvru_relax (
    input  dvru_pkg::t_relax_req i_req,
    output dvru_pkg::t_relax_rsp o_rsp
);
    import dvru_pkg::*;

    logic [COST_BITS:0] w_full;

    always_comb begin
        w_full     = {1'b0, i_req.to_send} + {1'b0, i_req.via};
        o_rsp.sum  = w_full[COST_BITS] ? COST_MAX : w_full[COST_BITS-1:0];
        // if not skipped and via != 0: take where no route or a dearer one
        o_rsp.take = !i_req.skip && (i_req.via != '0) &&
                     ((i_req.old == '0) || (i_req.old > o_rsp.sum));
    end

endmodule

/* hw/rtl/distance_vector_route_update.sv */
// Top level: distance-vector route table with load, exchange and query requests.
`timescale 1ns / 1ps
// After reset the block sweeps its 1024-entry table to clear it, taking no request meanwhile
// (node_count writes are taken at any time). A request is then handled one at a time: an
// exchange makes one pass over the receiver's row through the shared relaxation unit and
// the two read ports of the table memory. A finished result waits in the output register
// while the next request is accepted. s_axis_tdata holds node_a [4:0], node_b [9:5],
// link_cost [25:10]; s_axis_tuser holds cmd. m_axis_tdata holds route_cost [15:0],
// next_hop [21:16], updated_count [27:22]; m_axis_tuser holds status.
module distance_vector_route_update (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_wdata,   // node_count
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // node_a, node_b, link_cost, zero fill
    input  logic [1:0]  s_axis_tuser,  // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // route_cost, next_hop, updated_count, zero fill
    output logic [1:0]  m_axis_tuser   // status
);
    import dvru_pkg::*;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_LOAD1 = 8'b0000_0100,
        S_LOAD2 = 8'b0000_1000,
        S_LOOK  = 8'b0001_0000,
        S_CHECK = 8'b0010_0000,
        S_WALK  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic [5:0]            r_node_count;
    logic [ADDR_BITS-1:0]  r_clr, n_clr;
    logic [1:0]            r_cmd;
    logic [NODE_BITS-1:0]  r_a, r_b;
    logic [COST_BITS-1:0]  r_cost;
    logic [CNT_BITS-1:0]   r_n;
    logic [COST_BITS-1:0]  r_to_send, n_to_send;
    logic [CNT_BITS-1:0]   r_idx, n_idx;
    logic                  r_pend_v, n_pend_v;
    logic [NODE_BITS-1:0]  r_pend_idx, n_pend_idx;
    logic [CNT_BITS-1:0]   r_upd, n_upd;
    logic [1:0]            r_res_status, n_res_status;
    logic [COST_BITS-1:0]  r_res_cost, n_res_cost;
    logic [HOP_BITS-1:0]   r_res_hop, n_res_hop;

    logic                  r_ovalid;
    logic [1:0]            r_o_status;
    logic [COST_BITS-1:0]  r_o_cost;
    logic [HOP_BITS-1:0]   r_o_hop;
    logic [CNT_BITS-1:0]   r_o_upd;

    logic                  w_accept;
    logic [1:0]            w_cmd;
    logic [NODE_BITS-1:0]  w_a, w_b;
    logic [CNT_BITS-1:0]   w_n;
    logic                  w_bad;
    logic                  w_we;
    logic [ADDR_BITS-1:0]  w_waddr, w_raddr0, w_raddr1;
    t_entry                w_wdata, w_rd0, w_rd1;
    logic                  w_issue;
    logic                  w_out_free;
    t_relax_req            w_req;
    t_relax_rsp            w_rsp;

    assign w_cmd    = s_axis_tuser;
    assign w_a      = s_axis_tdata[4:0];
    assign w_b      = s_axis_tdata[9:5];
    assign w_n      = (r_node_count > 6'(MAX_NODES)) ? CNT_BITS'(MAX_NODES)
                                                     : r_node_count[CNT_BITS-1:0];
    assign w_bad    = (w_cmd == CMD_SPARE) || ({1'b0, w_a} >= w_n) || ({1'b0, w_b} >= w_n) ||
                      (w_a == w_b);
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_ovalid || m_axis_tready;
    assign w_issue       = (r_state == S_WALK) && (r_idx < r_n);

    dvru_ram #(
        .ADDR_W(ADDR_BITS),
        .DATA_W(ENTRY_BITS)
    ) u_ram (
        .i_clk    (i_clk),
        .i_we     (w_we),
        .i_waddr  (w_waddr),
        .i_wdata  (w_wdata),
        .i_raddr0 (w_raddr0),
        .i_raddr1 (w_raddr1),
        .o_rdata0 (w_rd0),
        .o_rdata1 (w_rd1)
    );

    always_comb begin
        w_req.skip    = (r_pend_idx == r_b);
        w_req.to_send = r_to_send;
        w_req.via     = w_rd0.cost;
        w_req.old     = w_rd1.cost;
    end

    dvru_relax u_relax (
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    // memory port steering
    always_comb begin
        w_we     = 1'b0;
        w_waddr  = {r_b, r_pend_idx};
        w_wdata  = '{mark: w_rd1.mark, hop: HOP_BITS'(r_a), cost: w_rsp.sum};
        w_raddr0 = {r_a, r_idx[NODE_BITS-1:0]};
        w_raddr1 = {r_b, r_idx[NODE_BITS-1:0]};
        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '{mark: 1'b0, hop: HOP_NONE, cost: '0};
            end
            S_LOAD1: begin
                w_we    = 1'b1;
                w_waddr = {r_a, r_b};
                w_wdata = '{mark: (r_cost != '0), hop: HOP_NONE, cost: r_cost};
            end
            S_LOAD2: begin
                w_we    = 1'b1;
                w_waddr = {r_b, r_a};
                w_wdata = '{mark: (r_cost != '0), hop: HOP_NONE, cost: r_cost};
            end
            S_LOOK: begin
                w_raddr0 = (r_cmd == CMD_QUERY) ? {r_a, r_b} : {r_b, r_a};
            end
            S_WALK: begin
                w_we = r_pend_v && w_rsp.take;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_to_send    = r_to_send;
        n_idx        = r_idx;
        n_pend_v     = 1'b0;
        n_pend_idx   = r_idx[NODE_BITS-1:0];
        n_upd        = r_upd;
        n_res_status = r_res_status;
        n_res_cost   = r_res_cost;
        n_res_hop    = r_res_hop;
        unique case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == ADDR_BITS'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_res_status = ST_OK;
                n_res_cost   = '0;
                n_res_hop    = HOP_NONE;
                n_upd        = '0;
                n_idx        = '0;
                if (w_accept) begin
                    if (w_bad) begin
                        n_res_status = ST_BAD;
                        n_state      = S_DONE;
                    end else if (w_cmd == CMD_LOAD) begin
                        n_state = S_LOAD1;
                    end else begin
                        n_state = S_LOOK;
                    end
                end
            end
            S_LOAD1: n_state = S_LOAD2;
            S_LOAD2: n_state = S_DONE;
            S_LOOK:  n_state = S_CHECK;
            S_CHECK: begin
                if (r_cmd == CMD_QUERY) begin
                    n_res_cost = w_rd0.cost;
                    n_res_hop  = w_rd0.hop;
                    n_state    = S_DONE;
                end else if (!w_rd0.mark) begin
                    n_res_status = ST_NO_LINK;
                    n_state      = S_DONE;
                end else begin
                    n_to_send = w_rd0.cost;
                    n_state   = S_WALK;
                end
            end
            S_WALK: begin
                // read entry idx while the previous one is relaxed and written back
                n_pend_v = w_issue;
                if (w_issue) begin
                    n_idx = r_idx + 1'b1;
                end
                if (r_pend_v && w_rsp.take) begin
                    n_upd = r_upd + 1'b1;
                end
                if (!w_issue && !r_pend_v) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_node_count <= 6'd32;
            r_ovalid     <= 1'b0;
            r_pend_v     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_pend_v <= n_pend_v;
            if (i_cfg_we) begin
                r_node_count <= i_cfg_wdata;
            end
            if ((r_state == S_DONE) && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_to_send    <= n_to_send;
        r_idx        <= n_idx;
        r_pend_idx   <= n_pend_idx;
        r_upd        <= n_upd;
        r_res_status <= n_res_status;
        r_res_cost   <= n_res_cost;
        r_res_hop    <= n_res_hop;
        if (w_accept) begin
            r_cmd  <= w_cmd;
            r_a    <= w_a;
            r_b    <= w_b;
            r_cost <= s_axis_tdata[25:10];
            r_n    <= w_n;
        end
        if ((r_state == S_DONE) && w_out_free) begin
            r_o_status <= r_res_status;
            r_o_cost   <= r_res_cost;
            r_o_hop    <= r_res_hop;
            r_o_upd    <= r_upd;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_o_status;
    assign m_axis_tdata  = {4'b0, r_o_upd, r_o_hop, r_o_cost};

endmodule

/* tb/sv/dvru_route_checker.sv */
// Route table checker: predicts each reply of the route update block and compares it.
`timescale 1ns / 1ps
module dvru_route_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_wdata,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [31:0] i_req_data,   // node_a, node_b, link_cost, zero fill
    input  logic [1:0]  i_req_user,   // cmd
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic [31:0] i_rsp_data,   // route_cost, next_hop, updated_count, zero fill
    input  logic [1:0]  i_rsp_user,   // status
    output int          o_pending,
    output int          o_fail_count
);
    import dvru_pkg::*;

    typedef struct packed {
        logic [1:0]           status;
        logic [COST_BITS-1:0] cost;
        logic [HOP_BITS-1:0]  hop;
        logic [CNT_BITS-1:0]  updated;
    } t_route_reply;

    logic [COST_BITS-1:0] route_cost [CELLS];
    logic [HOP_BITS-1:0]  route_hop  [CELLS];
    logic                 direct_link [CELLS];
    logic [5:0]           node_limit;
    t_route_reply         reply_q [$];
    int                   fails = 0;

    function automatic int cell_ix(int row, int col);
        return row * MAX_NODES + col;
    endfunction

    // Apply one request to the shadow tables and return the reply it should give.
    function automatic t_route_reply apply_request(logic [1:0] cmd, logic [31:0] data);
        t_route_reply         r;
        int                   a;
        int                   b;
        int                   n;
        int                   i;
        int                   count;
        logic [COST_BITS-1:0] cost;
        logic [COST_BITS-1:0] to_send;
        logic [COST_BITS-1:0] via;
        logic [COST_BITS-1:0] old;
        logic [COST_BITS:0]   sum;
        a = int'(data[4:0]);
        b = int'(data[9:5]);
        cost = data[25:10];
        n = (int'(node_limit) > MAX_NODES) ? MAX_NODES : int'(node_limit);
        count = 0;
        r.status = ST_OK;
        r.cost = '0;
        r.hop = HOP_NONE;
        r.updated = '0;
        if (a >= n || b >= n || a == b) begin
            r.status = ST_BAD;
        end else begin
            case (cmd)
                CMD_LOAD: begin
                    // zero cost removes the link in both directions
                    route_cost[cell_ix(a, b)] = cost;
                    route_cost[cell_ix(b, a)] = cost;
                    route_hop[cell_ix(a, b)] = HOP_NONE;
                    route_hop[cell_ix(b, a)] = HOP_NONE;
                    direct_link[cell_ix(a, b)] = (cost != '0);
                    direct_link[cell_ix(b, a)] = (cost != '0);
                end
                CMD_EXCH: begin
                    if (!direct_link[cell_ix(b, a)]) begin
                        r.status = ST_NO_LINK;
                    end else begin
                        to_send = route_cost[cell_ix(b, a)];
                        for (i = 0; i < n; i++) begin
                            via = route_cost[cell_ix(a, i)];
                            old = route_cost[cell_ix(b, i)];
                            if (via != '0 && i != b) begin
                                sum = {1'b0, to_send} + {1'b0, via};
                                if (sum[COST_BITS])
                                    sum = {1'b0, COST_MAX};
                                // an equal sum keeps the stored route
                                if (old == '0 || old > sum[COST_BITS-1:0]) begin
                                    route_cost[cell_ix(b, i)] = sum[COST_BITS-1:0];
                                    route_hop[cell_ix(b, i)] = HOP_BITS'(a);
                                    count++;
                                end
                            end
                        end
                        r.updated = CNT_BITS'(count);
                    end
                end
                CMD_QUERY: begin
                    r.cost = route_cost[cell_ix(a, b)];
                    r.hop = route_hop[cell_ix(a, b)];
                end
                default: r.status = ST_BAD;
            endcase
        end
        return r;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_route_reply want;
        t_route_reply got;
        int           k;
        if (!i_rst_n) begin
            for (k = 0; k < CELLS; k++) begin
                route_cost[k] = '0;
                route_hop[k] = HOP_NONE;
                direct_link[k] = 1'b0;
            end
            node_limit = 6'd32;
            reply_q.delete();
        end else begin
            // retire replies before taking this edge's request: a reply never belongs to it
            if (i_rsp_valid && i_rsp_ready) begin
                got.status = i_rsp_user;
                got.cost = i_rsp_data[15:0];
                got.hop = i_rsp_data[21:16];
                got.updated = i_rsp_data[27:22];
                if (reply_q.size() == 0) begin
                    $error("reply with no request outstanding: status %0d", got.status);
                    fails++;
                end else begin
                    want = reply_q.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("route_cost", want.cost, got.cost);
                    check_field("next_hop", want.hop, got.hop);
                    check_field("updated_count", want.updated, got.updated);
                end
            end
            if (i_req_valid && i_req_ready)
                reply_q.push_back(apply_request(i_req_user, i_req_data));
            if (i_cfg_we)
                node_limit = i_cfg_wdata;
        end
        o_pending <= reply_q.size();
        o_fail_count <= fails;
    end

endmodule

/* tb/sv/tb_top.sv */
// Testbench top: drives requests and node_count settings into the route table, gives the verdict.
`timescale 1ns / 1ps
module tb_top;
    import dvru_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [5:0]  i_cfg_wdata = 6'd32;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // node_a, node_b, link_cost, zero fill
    logic [1:0]  s_axis_tuser = '0;   // cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // route_cost, next_hop, updated_count, zero fill
    logic [1:0]  m_axis_tuser;        // status
    int          pending;
    int          fail_count;

    int          node_now = 32;
    int          link_a [$];
    int          link_b [$];
    bit          src_calm = 1'b0;
    bit          sink_calm = 1'b0;
    int          sink_hold = 0;
    int          phase_nodes [0:7] = '{4, 32, 63, 0, 1, 12, 2, 32};
    int          phase_items [0:7] = '{300, 450, 250, 40, 40, 350, 120, 350};

    always #2 i_clk = ~i_clk;

    distance_vector_route_update uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    dvru_route_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_data   (s_axis_tdata),
        .i_req_user   (s_axis_tuser),
        .i_rsp_valid  (m_axis_tvalid),
        .i_rsp_ready  (m_axis_tready),
        .i_rsp_data   (m_axis_tdata),
        .i_rsp_user   (m_axis_tuser),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_cost();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 0;
        else if (r < 10)
            return $urandom_range(65000, 65535);
        else if (r < 15)
            return $urandom_range(32768, 65535);
        return $urandom_range(1, 40);
    endfunction

    // Called on a rising edge; returns on the edge that accepts the request.
    task automatic send_req(logic [1:0] cmd, int a, int b, int cost);
        int gap;
        if ($urandom_range(0, 149) == 0)
            src_calm = !src_calm;
        gap = src_calm ? 0 : idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {6'd0, 16'(cost), 5'(b), 5'(a)};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Hold off new requests until every reply is back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic set_nodes(int count);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= 6'(count);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        node_now = count;
        link_a.delete();
        link_b.delete();
    endtask

    task automatic random_req();
        int eff;
        int r;
        int a;
        int b;
        int k;
        eff = (node_now > MAX_NODES) ? MAX_NODES : node_now;
        r = $urandom_range(0, 99);
        a = (eff > 0) ? $urandom_range(0, eff - 1) : 0;
        b = (eff > 1) ? (a + $urandom_range(1, eff - 1)) % eff : 0;
        if (eff < 2 || r < 8) begin
            send_req(2'($urandom_range(0, 3)), $urandom_range(0, 31), $urandom_range(0, 31),
                     $urandom_range(0, 65535));
        end else if (r < 33) begin
            send_req(CMD_LOAD, a, b, pick_cost());
            link_a.push_back(a);
            link_b.push_back(b);
            if (link_a.size() > 64) begin
                void'(link_a.pop_front());
                void'(link_b.pop_front());
            end
        end else if (r < 80 && link_a.size() > 0) begin
            // exchange over a loaded link, either direction
            k = $urandom_range(0, link_a.size() - 1);
            if ($urandom_range(0, 1))
                send_req(CMD_EXCH, link_a[k], link_b[k], $urandom_range(0, 65535));
            else
                send_req(CMD_EXCH, link_b[k], link_a[k], $urandom_range(0, 65535));
        end else begin
            send_req((r < 90) ? CMD_QUERY : CMD_EXCH, a, b, $urandom_range(0, 65535));
        end
    endtask

    always @(posedge i_clk) begin
        if (sink_hold > 0) begin
            m_axis_tready <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 199) == 0)
                sink_calm <= !sink_calm;
            if (!sink_calm && $urandom_range(0, 3) == 0)
                sink_hold <= idle_len();
        end
    end

    initial begin : stimulus
        int ph;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_req(CMD_QUERY, 0, 31, 0);           // empty table
        send_req(CMD_LOAD, 0, 1, 5);
        send_req(CMD_LOAD, 1, 2, 7);
        send_req(CMD_LOAD, 2, 31, 65535);        // largest cost
        send_req(CMD_EXCH, 1, 0, 0);
        send_req(CMD_EXCH, 2, 1, 0);             // sum saturates
        send_req(CMD_EXCH, 1, 0, 0);             // equal sum keeps old route
        send_req(CMD_QUERY, 0, 2, 0);
        send_req(CMD_QUERY, 0, 31, 0);
        send_req(CMD_EXCH, 3, 0, 0);             // no direct link
        send_req(CMD_LOAD, 5, 5, 9);             // equal ends
        send_req(CMD_SPARE, 0, 1, 4);            // unused cmd
        send_req(CMD_LOAD, 0, 1, 0);             // remove link
        send_req(CMD_EXCH, 1, 0, 0);
        send_req(CMD_QUERY, 1, 0, 0);
        send_req(CMD_LOAD, 31, 30, 1);           // smallest cost
        send_req(CMD_EXCH, 31, 30, 0);
        send_req(CMD_EXCH, 30, 31, 0);
        send_req(CMD_QUERY, 30, 2, 0);
        send_req(CMD_LOAD, 0, 2, 3);
        send_req(CMD_EXCH, 2, 0, 65535);
        send_req(CMD_QUERY, 0, 1, 0);
        send_req(CMD_QUERY, 31, 0, 65535);

        for (ph = 0; ph < 8; ph++) begin
            set_nodes(phase_nodes[ph]);
            repeat (phase_items[ph]) random_req();
        end

        drain();
        repeat (60) @(posedge i_clk);
        if (fail_count == 0)
            $display("distance_vector_route_update: match");
        else
            $display("distance_vector_route_update: mismatch");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("distance_vector_route_update: mismatch");
        $finish;
    end

endmodule

/* distance_vector_route_update.f */
hw/rtl/dvru_pkg.sv
hw/rtl/dvru_ram.sv
hw/rtl/dvru_relax.sv
hw/rtl/distance_vector_route_update.sv
tb/sv/dvru_route_checker.sv
tb/sv/tb_top.sv
